// File: src/fnpll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// fnpll_pkg: types, constants and the control store shared by the retune word generator.
// No dependencies.
package fnpll_pkg;

  localparam logic [15:0] FREQ_MIN      = 16'd350;
  localparam logic [15:0] FREQ_MAX      = 16'd44000;
  localparam logic [22:0] VCO_LOW       = 23'd2200;
  localparam logic [22:0] VCO_HIGH      = 23'd4400;
  localparam logic [9:0]  MOD_FULL      = 10'd1000;
  localparam logic [3:0]  MAX_DOUBLINGS = 4'd10;
  localparam logic [3:0]  K_WRAP        = 4'd7;
  localparam logic [15:0] DIV10_RECIP   = 16'd52429;
  localparam logic [17:0] DIV5_RECIP    = 18'd205;

  localparam logic [1:0] REG_RF_OFF = 2'd0;
  localparam logic [1:0] REG_R1     = 2'd1;
  localparam logic [1:0] REG_R4     = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MHZ,
    OP_SRCH,
    OP_PROD,
    OP_QUO,
    OP_REM,
    OP_FRAC,
    OP_RED5,
    OP_RED2,
    OP_PACK,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN,
    COND_SRCH,
    COND_NO5,
    COND_NO2,
    COND_OUT
  } cond_e;

  typedef enum logic [1:0] {
    SEL_RF_OFF,
    SEL_R1,
    SEL_R0,
    SEL_R4
  } sel_e;

  typedef struct packed {
    op_e        op;
    cond_e      cond;
    logic [3:0] target;
    sel_e       sel;
    logic       last;
  } ucode_t;

  // Control store: step advances to target when cond holds, else repeats.
  function automatic ucode_t ucode_rom(input logic [3:0] pc);
    ucode_t w;
    w = '{op: OP_NONE, cond: COND_ALWAYS, target: 4'd0, sel: SEL_RF_OFF, last: 1'b0};
    case (pc)
      4'd0:  w = '{OP_LOAD, COND_IN,     4'd1,  SEL_RF_OFF, 1'b0};
      4'd1:  w = '{OP_MHZ,  COND_ALWAYS, 4'd2,  SEL_RF_OFF, 1'b0};
      4'd2:  w = '{OP_SRCH, COND_SRCH,   4'd3,  SEL_RF_OFF, 1'b0};
      4'd3:  w = '{OP_PROD, COND_ALWAYS, 4'd4,  SEL_RF_OFF, 1'b0};
      4'd4:  w = '{OP_QUO,  COND_ALWAYS, 4'd5,  SEL_RF_OFF, 1'b0};
      4'd5:  w = '{OP_REM,  COND_ALWAYS, 4'd6,  SEL_RF_OFF, 1'b0};
      4'd6:  w = '{OP_FRAC, COND_ALWAYS, 4'd7,  SEL_RF_OFF, 1'b0};
      4'd7:  w = '{OP_RED5, COND_NO5,    4'd8,  SEL_RF_OFF, 1'b0};
      4'd8:  w = '{OP_RED2, COND_NO2,    4'd9,  SEL_RF_OFF, 1'b0};
      4'd9:  w = '{OP_PACK, COND_ALWAYS, 4'd10, SEL_RF_OFF, 1'b0};
      4'd10: w = '{OP_EMIT, COND_OUT,    4'd11, SEL_RF_OFF, 1'b0};
      4'd11: w = '{OP_EMIT, COND_OUT,    4'd12, SEL_R1,     1'b0};
      4'd12: w = '{OP_EMIT, COND_OUT,    4'd13, SEL_R0,     1'b0};
      4'd13: w = '{OP_EMIT, COND_OUT,    4'd0,  SEL_R4,     1'b1};
      default: w = '{OP_NONE, COND_ALWAYS, 4'd0, SEL_RF_OFF, 1'b0};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: src/frac_n_pll_register_words.sv
`timescale 1ns / 1ps
`default_nettype none
// frac_n_pll_register_words: retune word generator for a fractional-N synthesizer.
// Depends on fnpll_pkg.
//
// Each input transaction carries a frequency in 0.1 MHz; the block answers with four
// 32-bit words (RF-off, R1, R0, R4), tlast on the fourth. One request is handled at a
// time, under a 14-step control program. Each request is loaded, scaled to MHz and
// searched for its divider; then the VCO product, the quotient and the remainder by
// PFD_TENTHS_SCALE (reciprocal multiplications) and the fraction are formed in turn, the
// fraction is reduced by 5 and then by 2, the words are packed and the four are sent. The
// search and the reductions repeat their steps, and an output stall holds the words. The
// user must write the config registers (byte addresses 0, 4, 8) only while idle; not enforced.
module frac_n_pll_register_words #(
  parameter int PFD_TENTHS_SCALE = 250
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] freq_tenths_mhz
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] reg_word
  output logic             m_axis_tlast,   // last_word
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import fnpll_pkg::*;

  // Reciprocals are exact: dividend times rounding error stays below 2^shift.
  localparam int ProdW  = 16;
  localparam int ScaleW = $clog2(PFD_TENTHS_SCALE);
  localparam int RemW   = (ScaleW > 0) ? ScaleW : 1;
  localparam int Shift1 = ProdW + ScaleW;
  localparam int MulW1  = Shift1 + ProdW;
  localparam int Shift2 = 2 * ScaleW + 10;
  localparam int MulW2  = Shift2 + 10;
  localparam logic [63:0] Scale64     = 64'(PFD_TENTHS_SCALE);
  localparam logic [63:0] Recip1Full  = ((64'd1 << Shift1) + Scale64 - 64'd1) / Scale64;
  localparam logic [63:0] Recip2Full  = ((64'd1 << Shift2) + Scale64 - 64'd1) / Scale64;
  localparam logic [63:0] FracMulFull = Recip2Full * 64'(MOD_FULL);
  localparam logic [MulW1-1:0] Recip1  = Recip1Full[MulW1-1:0];
  localparam logic [MulW2-1:0] FracMul = FracMulFull[MulW2-1:0];
  localparam logic [ProdW-1:0] PScale  = ProdW'(PFD_TENTHS_SCALE);

  logic [31:0] rf_off_q, r1_base_q, r4_base_q;
  logic [3:0]  pc_q, pc_d;
  ucode_t      uc;

  logic [15:0]       f_q;
  logic [12:0]       mhz_q;
  logic [3:0]        k_q;
  logic [ProdW-1:0]  prod_q, quo_q;
  logic [RemW-1:0]   rem_q;
  logic [16:0]       ival_q;
  logic [9:0]        frac_q, mod_q;
  logic [31:0]       r0_q, r1_q, r4_q;

  logic [15:0] f_clamp;
  logic [31:0] mhz_prod;
  logic [22:0] vco;
  logic        srch_done;
  logic [MulW1-1:0] quo_prod;
  logic [ProdW-1:0] quo_scaled;
  logic [ProdW-1:0] rem_full;
  logic [MulW2-1:0] frac_prod;
  logic [17:0] frac_p5, mod_p5;
  logic [7:0]  frac_q5, mod_q5;
  logic [9:0]  frac_x5, mod_x5;
  logic        both5, both2;
  logic [2:0]  k_mod7;
  logic        go;

  // Config port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_off_q  <= 32'h008C_883C;
      r1_base_q <= 32'h0000_8001;
      r4_base_q <= 32'h008C_803C;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_RF_OFF: rf_off_q  <= pwdata;
        REG_R1:     r1_base_q <= pwdata;
        REG_R4:     r4_base_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RF_OFF: prdata = rf_off_q;
      REG_R1:     prdata = r1_base_q;
      REG_R4:     prdata = r4_base_q;
      default:    prdata = 32'd0;
    endcase
  end

  // Sequencer
  assign uc            = ucode_rom(pc_q);
  assign s_axis_tready = (uc.op == OP_LOAD);
  assign m_axis_tvalid = (uc.op == OP_EMIT);
  assign m_axis_tlast  = uc.last;

  always_comb begin
    case (uc.sel)
      SEL_RF_OFF: m_axis_tdata = rf_off_q;
      SEL_R1:     m_axis_tdata = r1_q;
      SEL_R0:     m_axis_tdata = r0_q;
      SEL_R4:     m_axis_tdata = r4_q;
      default:    m_axis_tdata = rf_off_q;
    endcase
  end

  // Datapath terms
  always_comb begin
    if (s_axis_tdata < FREQ_MIN) begin
      f_clamp = FREQ_MIN;
    end else if (s_axis_tdata > FREQ_MAX) begin
      f_clamp = FREQ_MAX;
    end else begin
      f_clamp = s_axis_tdata;
    end
  end

  assign mhz_prod  = {16'd0, f_q} * {16'd0, DIV10_RECIP};
  assign vco       = {10'd0, mhz_q} << k_q;
  assign srch_done = ((vco >= VCO_LOW) && (vco <= VCO_HIGH)) || (k_q == MAX_DOUBLINGS);

  assign quo_prod   = {{Shift1{1'b0}}, prod_q} * Recip1;
  assign quo_scaled = quo_q * PScale;
  assign rem_full   = prod_q - quo_scaled;
  assign frac_prod  = {{(MulW2 - RemW){1'b0}}, rem_q} * FracMul;

  assign frac_p5 = {8'd0, frac_q} * DIV5_RECIP;
  assign mod_p5  = {8'd0, mod_q} * DIV5_RECIP;
  assign frac_q5 = frac_p5[17:10];
  assign mod_q5  = mod_p5[17:10];
  assign frac_x5 = {frac_q5, 2'b00} + {2'b00, frac_q5};
  assign mod_x5  = {mod_q5, 2'b00} + {2'b00, mod_q5};
  assign both5   = (frac_x5 == frac_q) && (mod_x5 == mod_q);
  assign both2   = !frac_q[0] && !mod_q[0];

  assign k_mod7 = (k_q >= K_WRAP) ? 3'(k_q - K_WRAP) : k_q[2:0];

  always_comb begin
    case (uc.cond)
      COND_ALWAYS: go = 1'b1;
      COND_IN:     go = s_axis_tvalid && s_axis_tready;
      COND_SRCH:   go = srch_done;
      COND_NO5:    go = !both5;
      COND_NO2:    go = !both2;
      COND_OUT:    go = m_axis_tvalid && m_axis_tready;
      default:     go = 1'b1;
    endcase
    pc_d = go ? uc.target : pc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= 4'd0;
    end else begin
      pc_q <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (uc.op)
      OP_LOAD: begin
        f_q <= f_clamp;
        k_q <= 4'd0;
      end
      OP_MHZ: begin
        mhz_q <= mhz_prod[31:19];
      end
      OP_SRCH: begin
        if (!srch_done) begin
          k_q <= k_q + 4'd1;
        end
      end
      OP_PROD: begin
        // below 2^16 for any clamped request
        prod_q <= f_q << k_q;
      end
      OP_QUO: begin
        quo_q <= quo_prod[Shift1 +: ProdW];
      end
      OP_REM: begin
        ival_q <= {1'b0, quo_q};
        rem_q  <= rem_full[RemW-1:0];
      end
      OP_FRAC: begin
        frac_q <= frac_prod[Shift2 +: 10];
        mod_q  <= MOD_FULL;
      end
      OP_RED5: begin
        if (both5) begin
          frac_q <= {2'b00, frac_q5};
          mod_q  <= {2'b00, mod_q5};
        end
      end
      OP_RED2: begin
        if (both2) begin
          frac_q <= {1'b0, frac_q[9:1]};
          mod_q  <= {1'b0, mod_q[9:1]};
        end
      end
      OP_PACK: begin
        r0_q <= {ival_q, 15'd0} + {19'd0, frac_q, 3'b000};
        r1_q <= r1_base_q + {19'd0, mod_q, 3'b000};
        r4_q <= r4_base_q + {9'd0, k_mod7, 20'd0};
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
